@@ rtl/tasm_pkg.sv @@
// Shared types and constants for the three-axis sliding median filter.
package tasm_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int WINDOW_LENGTH_DEF = 5;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_x;
        t_sample sample_y;
        t_sample sample_z;
    } t_in_item;

    typedef struct packed {
        t_sample median_x;
        t_sample median_y;
        t_sample median_z;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic adv;
    } t_lane_ctl;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_merge_ctl;

endpackage

@@ rtl/three_axis_sliding_median.sv @@
// Top level of the three-axis sliding median filter.
//
//   Channel | Valid        | Ready        | Payload
//   --------+--------------+--------------+------------------------------
//   input   | i_in_valid   | o_in_ready   | i_in_item  (sample_x/y/z)
//   output  | o_out_valid  | i_out_ready  | o_out_item (median_x/y/z)
//
// One item is accepted per cycle while the output is not stalled; its result is
// registered in each stage below before it is shown.
// The stages are the window shift, the registered compare matrix and the output register.
// Reset clears the windows to zero and empties the pipeline.
// A stalled output holds the pipeline; up to three items can be in flight.
module three_axis_sliding_median import tasm_pkg::*; #(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic       r_s1_vld;
    logic       r_s2_vld;
    logic       w_en1;
    logic       w_en2;
    logic       w_en3;
    logic       w_out_vld;
    t_lane_ctl  w_lane_ctl;
    t_merge_ctl w_merge_ctl;
    t_sample    w_med_x;
    t_sample    w_med_y;
    t_sample    w_med_z;

    assign w_en3 = !w_out_vld || i_out_ready;
    assign w_en2 = !r_s2_vld || w_en3;
    assign w_en1 = !r_s1_vld || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_en2) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    assign w_lane_ctl.shift = i_in_valid && w_en1;
    assign w_lane_ctl.adv   = w_en2;
    assign w_merge_ctl.adv  = w_en3;
    assign w_merge_ctl.vld  = r_s2_vld;

    tasm_lane #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (i_in_item.sample_x),
        .o_median (w_med_x)
    );

    tasm_lane #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (i_in_item.sample_y),
        .o_median (w_med_y)
    );

    tasm_lane #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (i_in_item.sample_z),
        .o_median (w_med_z)
    );

    tasm_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_merge_ctl),
        .i_median_x (w_med_x),
        .i_median_y (w_med_y),
        .i_median_z (w_med_z),
        .o_vld      (w_out_vld),
        .o_item     (o_out_item)
    );

    assign o_in_ready  = w_en1;
    assign o_out_valid = w_out_vld;

endmodule

@@ rtl/tasm_lane.sv @@
// One axis lane: sample window, registered rank comparisons and median selection.
module tasm_lane import tasm_pkg::*; #(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_sample,
    output t_sample   o_median
);

    localparam int RW = $clog2(WINDOW_LENGTH);

    t_sample                  r_win [WINDOW_LENGTH];
    t_sample                  r_cpy [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] r_pre [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] n_pre [WINDOW_LENGTH];
    logic [RW-1:0]            w_rank [WINDOW_LENGTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_win[0] <= i_sample;
            for (int k = 1; k < WINDOW_LENGTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // Element j precedes element i when it is smaller, or equal and newer (lower in index).
    always_comb begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            for (int j = 0; j < WINDOW_LENGTH; j++) begin
                if (j < i) begin
                    n_pre[i][j] = (r_win[j] <= r_win[i]);
                end else if (j > i) begin
                    n_pre[i][j] = (r_win[j] < r_win[i]);
                end else begin
                    n_pre[i][j] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                r_pre[i] <= n_pre[i];
                r_cpy[i] <= r_win[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < WINDOW_LENGTH; j++) begin
                w_rank[i] = w_rank[i] + RW'(r_pre[i][j]);
            end
        end
    end

    generate
        if (WINDOW_LENGTH % 2 != 0) begin : g_odd
            localparam logic [RW-1:0] MID = RW'(WINDOW_LENGTH / 2);
            t_sample w_sel;

            always_comb begin
                w_sel = '0;
                for (int i = 0; i < WINDOW_LENGTH; i++) begin
                    if (w_rank[i] == MID) begin
                        w_sel = w_sel | r_cpy[i];
                    end
                end
            end

            assign o_median = w_sel;
        end else begin : g_even
            localparam logic [RW-1:0] LO = RW'(WINDOW_LENGTH / 2 - 1);
            localparam logic [RW-1:0] HI = RW'(WINDOW_LENGTH / 2);
            t_sample                     w_lo;
            t_sample                     w_hi;
            logic signed [SAMPLE_BITS:0] w_sum;

            always_comb begin
                w_lo = '0;
                w_hi = '0;
                for (int i = 0; i < WINDOW_LENGTH; i++) begin
                    if (w_rank[i] == LO) begin
                        w_lo = w_lo | r_cpy[i];
                    end
                    if (w_rank[i] == HI) begin
                        w_hi = w_hi | r_cpy[i];
                    end
                end
            end

            assign w_sum    = {w_lo[SAMPLE_BITS-1], w_lo} + {w_hi[SAMPLE_BITS-1], w_hi};
            assign o_median = w_sum[SAMPLE_BITS:1];
        end
    endgenerate

endmodule

@@ rtl/tasm_merge.sv @@
// Output stage that gathers the three lane medians into one registered result item.
module tasm_merge import tasm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_merge_ctl i_ctl,
    input  t_sample    i_median_x,
    input  t_sample    i_median_y,
    input  t_sample    i_median_z,
    output logic       o_vld,
    output t_out_item  o_item
);

    logic      r_vld;
    t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_item.median_x <= i_median_x;
            r_item.median_y <= i_median_y;
            r_item.median_z <= i_median_z;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

@@ rtl/tasm_checker.sv @@
// Port-level checker for the three-axis sliding median filter, bound to the top level.
module tasm_port_checker import tasm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic       w_acc;
    logic       w_del;
    logic [2:0] r_cnt;

    assign w_acc = i_in_valid && o_in_ready;
    assign w_del = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(w_acc) - 3'(w_del);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output item dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("Output item changed while stalled.");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 3'd0)
        else $error("Output item shown with no item in flight.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && r_cnt == 3'd0 |=> ##2 o_out_valid)
        else $error("Result of an item into an empty block not shown after two cycles.");

    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> o_in_ready && r_cnt <= 3'd3)
        else $error("Empty block does not accept an item.");

endmodule

bind three_axis_sliding_median tasm_port_checker u_tasm_port_checker (.*);

@@ test/tasm_checker.sv @@
// Checker that predicts and compares the medians of the three-axis sliding median filter.
`timescale 1ns / 100ps

module tasm_checker import tasm_pkg::*; #(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    t_sample   history[3][WINDOW_LENGTH];
    t_out_item expected_medians[$];

    function automatic t_sample axis_median(input int axis);
        t_sample                      sorted[WINDOW_LENGTH];
        t_sample                      v;
        logic signed [SAMPLE_BITS:0]  pair_sum;
        int                           i;
        int                           j;
        for (i = 0; i < WINDOW_LENGTH; i++) begin
            v = history[axis][i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (WINDOW_LENGTH % 2 != 0) begin
            return sorted[WINDOW_LENGTH/2];
        end
        // The mean of the two middle samples is rounded toward minus infinity.
        pair_sum = sorted[WINDOW_LENGTH/2-1] + sorted[WINDOW_LENGTH/2];
        return t_sample'(pair_sum >>> 1);
    endfunction

    task automatic shift_in_sample(input t_in_item item);
        t_sample   fresh[3];
        t_out_item medians;
        int        axis;
        int        k;
        fresh[0] = item.sample_x;
        fresh[1] = item.sample_y;
        fresh[2] = item.sample_z;
        for (axis = 0; axis < 3; axis++) begin
            for (k = WINDOW_LENGTH - 1; k > 0; k--) begin
                history[axis][k] = history[axis][k-1];
            end
            history[axis][0] = fresh[axis];
        end
        medians.median_x = axis_median(0);
        medians.median_y = axis_median(1);
        medians.median_z = axis_median(2);
        expected_medians.push_back(medians);
    endtask

    task automatic compare_medians(input t_out_item actual);
        t_out_item oldest;
        if (expected_medians.size() == 0) begin
            $error("unexpected result item: median_x %0d median_y %0d median_z %0d",
                   actual.median_x, actual.median_y, actual.median_z);
            o_fail_count++;
            return;
        end
        oldest = expected_medians.pop_front();
        if (actual.median_x !== oldest.median_x) begin
            $error("median_x: expected %0d, actual %0d", oldest.median_x, actual.median_x);
            o_fail_count++;
        end
        if (actual.median_y !== oldest.median_y) begin
            $error("median_y: expected %0d, actual %0d", oldest.median_y, actual.median_y);
            o_fail_count++;
        end
        if (actual.median_z !== oldest.median_z) begin
            $error("median_z: expected %0d, actual %0d", oldest.median_z, actual.median_z);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int axis = 0; axis < 3; axis++) begin
                for (int k = 0; k < WINDOW_LENGTH; k++) begin
                    history[axis][k] = '0;
                end
            end
            expected_medians.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_medians(i_out_item);
            end
            if (i_in_valid && i_in_ready) begin
                shift_in_sample(i_in_item);
            end
        end
        o_pending = expected_medians.size();
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top that drives sample items into the three-axis sliding median filter.
`timescale 1ns / 100ps

module tb_top;
    import tasm_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        idle_on;

    three_axis_sliding_median dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    tasm_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            6, 7: return t_sample'($urandom_range(0, 16) - 8);
            8, 9: begin
                case ($urandom_range(0, 6))
                    0: return 16'sh8000;
                    1: return 16'sh8001;
                    2: return -16'sd1;
                    3: return 16'sd0;
                    4: return 16'sd1;
                    5: return 16'sh7ffe;
                    default: return 16'sh7fff;
                endcase
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_sample(input t_sample sx, input t_sample sy, input t_sample sz);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item.sample_x = sx;
        in_item.sample_y = sy;
        in_item.sample_z = sz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        idle_on  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_on = 1'b1;
        for (int n = 0; n < 5; n++) begin
            send_sample(16'sh7fff, 16'sh8000, 16'sd0);
        end
        for (int n = 0; n < 5; n++) begin
            send_sample(16'sh8000, 16'sh7fff, -16'sd1);
        end
        for (int n = 1; n <= 5; n++) begin
            send_sample(t_sample'(n), t_sample'(-n),
                        (n % 2 != 0) ? 16'sh7fff : 16'sh8000);
        end
        for (int n = 0; n < 3; n++) begin
            send_sample(16'sd7, 16'sd7, 16'sd7);
        end
        send_sample(-16'sd1, 16'sd0, 16'sd1);
        send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
        send_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
        send_sample(16'sd7, 16'sd7, 16'sd8);
        drain_results();

        for (int n = 0; n < 1500; n++) begin
            idle_on = (n < 1300) && ((n / 150) % 3 != 2);
            if (n == 500 || n == 1000) begin
                drain_results();
            end
            send_sample(random_sample(), random_sample(), random_sample());
        end

        in_valid = 1'b0;
        idle_on  = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ three_axis_sliding_median.f @@
rtl/tasm_pkg.sv
rtl/tasm_lane.sv
rtl/tasm_merge.sv
rtl/three_axis_sliding_median.sv
rtl/tasm_checker.sv
test/tasm_checker.sv
test/tb_top.sv
